// File: rtl/rmavg_pkg.sv
// ----------------------------------------------------------------------------
// rmavg_pkg
// Shared constants and types for the ring moving average with warm-up.
// ----------------------------------------------------------------------------
package rmavg_pkg;

   localparam int WINDOW   = 50;
   localparam int SAMPLE_W = 24;
   localparam int POS_W    = $clog2(WINDOW);
   localparam int CNT_W    = $clog2(WINDOW + 1);
   localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW);
   localparam int STEP_W   = $clog2(SUM_W);

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // controller to datapath
   typedef struct packed {
      logic load_sample;
      logic update;
      logic prep;
      logic div_step;
      logic out_load;
   } rmavg_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rsp_free;
   } rmavg_sts_type;

endpackage

// File: rtl/rmavg_req_if.sv
// ----------------------------------------------------------------------------
// rmavg_req_if
// Sample channel: valid/ready handshake with one signed sample.
// ----------------------------------------------------------------------------
interface rmavg_req_if
   import rmavg_pkg::*;
   ();
   logic       valid;
   logic       ready;
   sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// File: rtl/rmavg_rsp_if.sv
// ----------------------------------------------------------------------------
// rmavg_rsp_if
// Result channel: valid/ready handshake with one signed average.
// ----------------------------------------------------------------------------
interface rmavg_rsp_if
   import rmavg_pkg::*;
   ();
   logic       valid;
   logic       ready;
   sample_type average;

   modport source (output valid, output average, input ready);
   modport sink   (input valid, input average, output ready);
endinterface

// File: rtl/rmavg_ctrl.sv
// ----------------------------------------------------------------------------
// rmavg_ctrl
// Sequencer: accept, ring update, divider setup, divide loop, result hand-off.
// ----------------------------------------------------------------------------
module rmavg_ctrl
   import rmavg_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  rmavg_sts_type sts,
   output rmavg_cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_UPDATE = 5'b00010,
      S_PREP   = 5'b00100,
      S_DIV    = 5'b01000,
      S_DONE   = 5'b10000
   } state_type;

   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load_sample = 1'b1;
               state_in        = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_PREP;
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            step_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // wait until the output register is free
            if (sts.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   a_accept_to_update: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_UPDATE)
      else $error("accepted transfer did not start a ring update");

   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && step_ff == STEP_LAST) |=> state_ff == S_DONE)
      else $error("divide loop did not end after its last step");

   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && step_ff != STEP_LAST) |=> state_ff == S_DIV)
      else $error("divide loop left early");

endmodule

// File: rtl/rmavg_dp.sv
// ----------------------------------------------------------------------------
// rmavg_dp
// Datapath: sample ring, running sum, restoring divider and output register.
// ----------------------------------------------------------------------------
module rmavg_dp
   import rmavg_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  rmavg_cmd_type cmd,
   output rmavg_sts_type sts,
   input  sample_type    req_sample,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output sample_type    rsp_average
);

   localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW);

   logic [SAMPLE_W-1:0] ring_mem [WINDOW];

   sample_type              sample_ff;
   sample_type              rd_ff;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic                    full_ff, full_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [SUM_W-1:0]        quo_ff, quo_in;
   logic [CNT_W-1:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]        div_ff;
   logic                    neg_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   sample_type              avg_ff;
   logic [CNT_W:0]          trial;
   logic [SAMPLE_W-1:0]     quo_low;

   assign sts.rsp_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_average  = avg_ff;

   // ring port: read old entry on accept, write new sample on update
   always_ff @(posedge clock) begin
      if (cmd.load_sample) begin
         sample_ff <= req_sample;
         rd_ff     <= ring_mem[pos_ff];
      end
      if (cmd.update) begin
         ring_mem[pos_ff] <= sample_ff;
      end
   end

   always_comb begin
      pos_in  = pos_ff;
      full_in = full_ff;
      sum_in  = sum_ff;
      if (cmd.update) begin
         sum_in = sum_ff + SUM_W'(sample_ff);
         if (full_ff) begin
            sum_in = sum_in - SUM_W'(rd_ff);
         end
         if (pos_ff == POS_LAST) begin
            pos_in  = '0;
            full_in = 1'b1;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   // restoring divide, one quotient bit per step
   assign trial = {rem_ff, quo_ff[SUM_W-1]};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      if (cmd.prep) begin
         quo_in = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
         rem_in = '0;
      end else if (cmd.div_step) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = CNT_W'(trial - {1'b0, div_ff});
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = CNT_W'(trial);
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
      end
   end

   assign quo_low = quo_ff[SAMPLE_W-1:0];

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (cmd.prep) begin
         neg_ff <= sum_ff[SUM_W-1];
         div_ff <= full_ff ? CNT_FULL : CNT_W'(pos_ff);
      end
      if (cmd.out_load) begin
         avg_ff <= neg_ff ? sample_type'(-quo_low) : sample_type'(quo_low);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         full_ff      <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         full_ff      <= full_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LAST)
      else $error("ring write position out of range");

   a_full_sticky: assert property (@(posedge clock) disable iff (reset)
      full_ff |=> full_ff)
      else $error("ring full flag dropped");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> rem_ff < div_ff)
      else $error("divider remainder not below divisor");

endmodule

// File: rtl/ring_moving_average_warmup_top.sv
// ----------------------------------------------------------------------------
// ring_moving_average_warmup_top
// Running mean of the most recent samples, with warm-up before the ring fills.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one signed 24-bit sample per transfer; rsp_chan returns
//   one signed 24-bit average per sample, in order. Until the ring of 50
//   samples has filled, the sum is divided by the number of samples seen;
//   after that by 50. Division truncates toward zero.
//   From accept to result valid: the old ring entry is read at the accepting
//   edge, then come the sum and ring update, the divider setup, the
//   bit-serial restoring divider and the load of the output register.
//   One item is in work at a time: a new sample is accepted only once the
//   last result has been loaded into the output register.
//   Reset clears the write position, the full flag, the running sum and the
//   output valid; ring contents are only read once written, so no clearing
//   pass is needed and req_chan.ready rises right after reset.
//   The output register lets a new sample be accepted while a result waits;
//   if the receiver stalls, the next result holds in the datapath and
//   req_chan stays not ready until the waiting result has been taken.
// ----------------------------------------------------------------------------
module ring_moving_average_warmup_top
   import rmavg_pkg::*;
(
   input logic         clock,
   input logic         reset,
   rmavg_req_if.sink   req_chan,
   rmavg_rsp_if.source rsp_chan
);

   rmavg_cmd_type cmd;
   rmavg_sts_type sts;

   rmavg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rmavg_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_sample  (req_chan.sample),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_average (rsp_chan.average)
   );

endmodule

// File: test/ring_moving_average_warmup_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ring_moving_average_warmup_top_tb
// Drives signed samples through the moving average block and checks every
// average against a running-sum predictor with a warm-up divisor, under random
// idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module ring_moving_average_warmup_top_tb
   import rmavg_pkg::*;
   ();

   localparam int          TOTAL_SAMPLES = 1900;
   localparam int          IDLE_PCT      = 17;
   localparam int          HOLD_CYCLES   = 600;
   localparam int          HOLD_AT       = 300;
   localparam int          QUIET_FROM    = 700;
   localparam int          QUIET_TO      = 1000;
   localparam int          DRAIN_CYCLES  = SUM_W + 10;
   localparam int unsigned CYCLE_LIMIT   = 1000000;
   localparam sample_type  SAMPLE_MAX    = sample_type'(24'h7FFFFF);
   localparam sample_type  SAMPLE_MIN    = sample_type'(24'h800000);

   typedef enum {
      BURST_UNIFORM,
      BURST_TOP,
      BURST_BOTTOM,
      BURST_NEAR_ZERO,
      BURST_SWING,
      BURST_ONE_BIT,
      BURST_CONSTANT
   } burst_kind_type;

   // running mean predictor plus the queue of averages still owed by the block
   class avg_scoreboard_type;
      sample_type  ring[WINDOW];
      int unsigned wr_pos;
      bit          filled;
      longint      running_sum;
      sample_type  pending_avg[$];
      int          mismatches;
      int          checked;

      function new();
         wr_pos      = 0;
         filled      = 1'b0;
         running_sum = 0;
         mismatches  = 0;
         checked     = 0;
      endfunction

      function void note_sample(sample_type s);
         longint divisor;
         if (filled)
            running_sum -= ring[wr_pos];
         running_sum += s;
         ring[wr_pos] = s;
         wr_pos++;
         if (wr_pos == WINDOW) begin
            wr_pos = 0;
            filled = 1'b1;
         end
         divisor = filled ? longint'(WINDOW) : longint'(wr_pos);
         // signed division truncates toward zero
         pending_avg.push_back(sample_type'(running_sum / divisor));
      endfunction

      function void check_average(sample_type got);
         sample_type want;
         checked++;
         if (pending_avg.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] average %0d arrived with no sample pending", $time, got);
            return;
         end
         want = pending_avg.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] average #%0d: expected %0d, got %0d",
                        $time, checked, want, got);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   int unsigned cycle_count = 0;
   int          n_sent = 0;
   int          extreme_runs = 0;
   bit          quiet_stretch = 1'b0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;
   avg_scoreboard_type sb = new();

   rmavg_req_if req_chan ();
   rmavg_rsp_if rsp_chan ();

   ring_moving_average_warmup_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
   end

   task automatic send_sample(input sample_type s);
      quiet_stretch = (n_sent >= QUIET_FROM) && (n_sent < QUIET_TO);
      while (!quiet_stretch && ($urandom_range(99) < IDLE_PCT)) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.sample <= s;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      sb.note_sample(s);
      n_sent++;
   endtask

   function automatic sample_type draw_sample(burst_kind_type kind, int idx, sample_type base);
      sample_type s;
      case (kind)
         BURST_TOP:       s = SAMPLE_MAX;
         BURST_BOTTOM:    s = SAMPLE_MIN;
         BURST_NEAR_ZERO: s = sample_type'(int'($urandom_range(400)) - 200);
         BURST_SWING:     s = idx[0] ? SAMPLE_MIN : SAMPLE_MAX;
         BURST_ONE_BIT: begin
            s = sample_type'(24'h1 << $urandom_range(SAMPLE_W - 1));
            if ($urandom_range(1))
               s = ~s;
         end
         BURST_CONSTANT:  s = base;
         default:         s = sample_type'($urandom);
      endcase
      return s;
   endfunction

   // result side: random stalls, a quiet stretch, and one long hold-off
   initial begin
      rsp_chan.ready <= 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_average(rsp_chan.average);
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!hold_done && sb.checked >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= quiet_stretch || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   initial begin
      sample_type     directed[$];
      burst_kind_type kind;
      sample_type     base;
      int             run_len;
      int             pick;

      reset          <= 1'b1;
      req_chan.valid  <= 1'b0;
      req_chan.sample <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // warm-up with extremes and odd negative sums that must round toward zero
      directed = '{sample_type'(0), sample_type'(-1), sample_type'(0), sample_type'(-2),
                   sample_type'(1), SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX,
                   sample_type'(-7), sample_type'(3), sample_type'(24'h555555),
                   sample_type'(24'hAAAAAA), SAMPLE_MIN, SAMPLE_MIN, sample_type'(-100),
                   sample_type'(100), sample_type'(24'h400000), SAMPLE_MAX, SAMPLE_MAX,
                   sample_type'(-1)};
      foreach (directed[i])
         send_sample(directed[i]);

      while (n_sent < TOTAL_SAMPLES) begin
         pick = $urandom_range(9);
         case (pick)
            4:       kind = BURST_TOP;
            5:       kind = BURST_BOTTOM;
            6:       kind = BURST_NEAR_ZERO;
            7:       kind = BURST_SWING;
            8:       kind = BURST_ONE_BIT;
            9:       kind = BURST_CONSTANT;
            default: kind = BURST_UNIFORM;
         endcase
         // runs of one extreme long enough to fill the window drive the sum to its limits
         if (kind == BURST_TOP || kind == BURST_BOTTOM) begin
            run_len = $urandom_range(70, WINDOW);
            extreme_runs++;
         end else begin
            run_len = $urandom_range(80, 1);
         end
         base = sample_type'($urandom);
         for (int j = 0; j < run_len && n_sent < TOTAL_SAMPLES; j++)
            send_sample(draw_sample(kind, j, base));
      end
      req_chan.valid <= 1'b0;

      while (sb.pending_avg.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d samples sent, %0d averages checked, %0d extreme runs, one %0d-cycle stall",
               n_sent, sb.checked, extreme_runs, HOLD_CYCLES);
      $display("warm-up, wrap to full and steady window all exercised in %0d cycles",
               cycle_count);
      if (sb.mismatches == 0 && sb.pending_avg.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches, %0d averages missing", sb.mismatches,
                  sb.pending_avg.size());
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// File: ring_moving_average_warmup_top.f
rtl/rmavg_pkg.sv
rtl/rmavg_req_if.sv
rtl/rmavg_rsp_if.sv
rtl/rmavg_ctrl.sv
rtl/rmavg_dp.sv
rtl/ring_moving_average_warmup_top.sv
test/ring_moving_average_warmup_top_tb.sv
